// File: hw/rtl/window_cooccurrence_pairs_macros.svh
// assertion macros for the co-occurrence pair generator
`ifndef WINDOW_COOCCURRENCE_PAIRS_MACROS_SVH
`define WINDOW_COOCCURRENCE_PAIRS_MACROS_SVH

// same-cycle implication under the block clock and reset
`define WCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication under the block clock and reset
`define WCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/wcp_pkg.sv
// types, constants and helpers shared by the co-occurrence pair generator
package wcp_pkg;

    localparam int ID_W           = 16;
    localparam int WT_W           = 16;
    localparam int WS_W           = 3;
    localparam int WM_W           = 2;
    localparam int NUM_WOFS       = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DEF_MAX_WINDOW = 5;
    localparam int DEF_ID_BITS    = 16;

    localparam logic [WT_W-1:0] ONE_Q14     = 16'd16384;
    localparam logic [WS_W-1:0] WS_RESET    = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE  = 3'd0,
        CFG_ORDERED_MODE = 3'd1,
        CFG_WEIGHT_MODE  = 3'd2,
        CFG_WOFS1        = 3'd3,
        CFG_WOFS2        = 3'd4,
        CFG_WOFS3        = 3'd5,
        CFG_WOFS4        = 3'd6,
        CFG_WOFS5        = 3'd7
    } t_cfg_idx;

    typedef enum logic [WM_W-1:0] {
        WM_UNIT   = 2'd0,
        WM_RECIP  = 2'd1,
        WM_CUSTOM = 2'd2
    } t_wmode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic span_zero;
        logic slot_free;
        logic last;
    } t_sts;

    // round-half-up reciprocal of the offset in Q2.14
    function automatic logic [WT_W-1:0] recip_q14(input logic [WS_W-1:0] d);
        logic [WT_W-1:0] r;
        case (d)
            3'd1:    r = 16'd16384;
            3'd2:    r = 16'd8192;
            3'd3:    r = 16'd5461;
            3'd4:    r = 16'd4096;
            3'd5:    r = 16'd3277;
            default: r = ONE_Q14;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/wcp_tok_if.sv
// token channel: valid, ready and one token item
interface wcp_tok_if;
    logic        valid;
    logic        ready;
    logic [15:0] token_id;
    logic        text_start;

    modport source (output valid, output token_id, output text_start, input ready);
    modport sink   (input valid, input token_id, input text_start, output ready);
endinterface

// File: hw/rtl/wcp_pair_if.sv
// pair channel: valid, ready and one pair item
interface wcp_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] target_id;
    logic [15:0] collocate_id;
    logic [15:0] pair_weight;
    logic        last_pair;

    modport source (output valid, output target_id, output collocate_id,
                    output pair_weight, output last_pair, input ready);
    modport sink   (input valid, input target_id, input collocate_id,
                    input pair_weight, input last_pair, output ready);
endinterface

// File: hw/rtl/window_cooccurrence_pairs.sv
// Sliding-window co-occurrence pair generator, top level.
// i_tok carries token items (token_id, text_start); a token is taken when
// valid and ready are both high. text_start clears the history of the text.
// o_pair carries one pair item per cycle at most: target_id, collocate_id,
// a Q2.14 pair_weight and last_pair on the final pair of a token.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write it only while the block is idle, as the block does not
// enforce this; registers take effect for the next token. A token that
// pairs with n earlier tokens (n up to window_size, at most MAX_WINDOW) is
// accepted first, then its pairs go out one per cycle unless the receiver
// stalls, from a single output register, oldest partner to nearest. A token
// with no partner causes no pair and the next token can follow in the next
// cycle. While a token's pairs are being emitted i_tok.ready stays low. If
// the receiver stalls, the pending pair holds in the output register and
// emission waits; the history only advances when the last pair is loaded.
// Reset (synchronous, active low) empties the history and the output
// register and restores the register defaults: window five, smaller id
// first, unit weight, all custom weights 1.0.
`include "window_cooccurrence_pairs_macros.svh"

module window_cooccurrence_pairs
    import wcp_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wcp_tok_if.sink               i_tok,
    wcp_pair_if.source            o_pair
);

    t_cmd cmd;
    t_sts sts;

    wcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .o_in_ready (i_tok.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wcp_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_token_id     (i_tok.token_id),
        .i_text_start   (i_tok.text_start),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (o_pair.ready),
        .o_out_valid    (o_pair.valid),
        .o_target_id    (o_pair.target_id),
        .o_collocate_id (o_pair.collocate_id),
        .o_pair_weight  (o_pair.pair_weight),
        .o_last_pair    (o_pair.last_pair)
    );

    // a pair is only loaded when the output register has room
    `WCP_ASSERT_IMP(a_emit_has_room, cmd.emit, sts.slot_free)
    // accepting a token and emitting a pair never overlap
    `WCP_ASSERT_IMP(a_accept_not_emit, cmd.accept, !cmd.emit)
    // after the final pair is loaded the block takes tokens again
    `WCP_ASSERT_NXT(a_ready_after_last, cmd.emit && sts.last, i_tok.ready)
    // a token with partners blocks the input while its pairs go out
    `WCP_ASSERT_NXT(a_busy_after_accept, cmd.accept && !sts.span_zero, !i_tok.ready)

endmodule

// File: hw/rtl/wcp_ctrl.sv
// controller: accepts a token, then sequences its pairs into the output register
module wcp_ctrl
    import wcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.span_zero) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/wcp_dp.sv
// datapath: registers, token history, pair build and output register
module wcp_dp
    import wcp_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ID_W-1:0]       i_token_id,
    input  logic                  i_text_start,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [ID_W-1:0]       o_target_id,
    output logic [ID_W-1:0]       o_collocate_id,
    output logic [WT_W-1:0]       o_pair_weight,
    output logic                  o_last_pair
);

    localparam int HIST_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_WINDOW);

    // configuration
    logic [WS_W-1:0] r_ws;
    logic            r_ordered;
    logic [WM_W-1:0] r_wmode;
    logic [WT_W-1:0] r_wofs [NUM_WOFS];

    // history and current item
    logic [HIST_W-1:0] r_hist [MAX_WINDOW];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [HIST_W-1:0] r_tok;
    logic [FILL_W-1:0] r_d;

    // output register
    logic            r_ov;
    logic            n_ov;
    logic [ID_W-1:0] r_tgt;
    logic [ID_W-1:0] r_col;
    logic [WT_W-1:0] r_wt;
    logic            r_last;

    logic [HIST_W-1:0] tok_m;
    logic [FILL_W-1:0] w_eff;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] span;
    logic              push;
    logic [HIST_W-1:0] push_tok;
    logic [HIST_W-1:0] prev;
    logic [HIST_W-1:0] pa;
    logic [HIST_W-1:0] pb;
    logic [WS_W-1:0]   d3;
    logic [WT_W-1:0]   wt;
    logic [WT_W-1:0]   wcust;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= WS_RESET;
            r_ordered <= 1'b0;
            r_wmode   <= WM_UNIT;
            for (int k = 0; k < NUM_WOFS; k++) begin
                r_wofs[k] <= ONE_Q14;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_SIZE:  r_ws      <= i_cfg_data[WS_W-1:0];
                CFG_ORDERED_MODE: r_ordered <= i_cfg_data[0];
                CFG_WEIGHT_MODE:  r_wmode   <= i_cfg_data[WM_W-1:0];
                CFG_WOFS1:        r_wofs[0] <= i_cfg_data[WT_W-1:0];
                CFG_WOFS2:        r_wofs[1] <= i_cfg_data[WT_W-1:0];
                CFG_WOFS3:        r_wofs[2] <= i_cfg_data[WT_W-1:0];
                CFG_WOFS4:        r_wofs[3] <= i_cfg_data[WT_W-1:0];
                CFG_WOFS5:        r_wofs[4] <= i_cfg_data[WT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign tok_m = HIST_W'(i_token_id);

    // window zero acts as one, larger windows saturate at the history depth
    always_comb begin
        if (r_ws == '0) begin
            w_eff = FILL_W'(1);
        end else if (r_ws > WS_W'(MAX_WINDOW)) begin
            w_eff = FILL_MAX;
        end else begin
            w_eff = FILL_W'(r_ws);
        end
    end

    assign fill_base = (i_cmd.accept && i_text_start) ? '0 : r_fill;
    assign span      = (fill_base < w_eff) ? fill_base : w_eff;

    assign push     = (i_cmd.accept && (span == '0)) || (i_cmd.emit && (r_d == FILL_W'(1)));
    assign push_tok = i_cmd.accept ? tok_m : r_tok;
    assign n_fill   = (fill_base == FILL_MAX) ? fill_base : fill_base + FILL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (push) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_hist[0] <= push_tok;
            for (int k = 1; k < MAX_WINDOW; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tok <= tok_m;
            r_d   <= span;
        end else if (i_cmd.emit) begin
            r_d   <= r_d - FILL_W'(1);
        end
    end

    // partner at the current offset
    always_comb begin
        prev = r_hist[0];
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (r_d == FILL_W'(k + 1)) begin
                prev = r_hist[k];
            end
        end
    end

    always_comb begin
        pa = prev;
        pb = r_tok;
        if (!r_ordered && (r_tok < prev)) begin
            pa = r_tok;
            pb = prev;
        end
    end

    assign d3 = WS_W'(r_d);

    always_comb begin
        wcust = r_wofs[0];
        for (int k = 0; k < NUM_WOFS; k++) begin
            if (d3 == WS_W'(k + 1)) begin
                wcust = r_wofs[k];
            end
        end
    end

    always_comb begin
        case (r_wmode)
            WM_RECIP:  wt = recip_q14(d3);
            WM_CUSTOM: wt = wcust;
            default:   wt = ONE_Q14;
        endcase
    end

    assign n_ov = i_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ov);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_tgt  <= ID_W'(pa);
            r_col  <= ID_W'(pb);
            r_wt   <= wt;
            r_last <= (r_d == FILL_W'(1));
        end
    end

    // a token with no partner in its text causes no pair
    assign o_sts.span_zero = i_text_start || (r_fill == '0);
    assign o_sts.slot_free = !r_ov || i_out_ready;
    assign o_sts.last      = (r_d == FILL_W'(1));

    assign o_out_valid    = r_ov;
    assign o_target_id    = r_tgt;
    assign o_collocate_id = r_col;
    assign o_pair_weight  = r_wt;
    assign o_last_pair    = r_last;

endmodule

// File: test/tb.sv
// testbench for the sliding-window co-occurrence pair generator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcp_pkg::*;

    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                MAX_WIN        = DEF_MAX_WINDOW;
    localparam logic [WM_W-1:0]   WM_SPARE       = 2'd3;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            start;
        bit              hold;
    } tok_rec;

    typedef struct {
        logic [ID_W-1:0] target;
        logic [ID_W-1:0] collocate;
        logic [WT_W-1:0] weight;
        logic            last;
    } pair_rec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wcp_tok_if  tok_ch();
    wcp_pair_if pair_ch();

    window_cooccurrence_pairs i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tok      (tok_ch),
        .o_pair     (pair_ch)
    );

    // mirror of the block's registers and token history
    logic [WS_W-1:0] cfg_window;
    logic            cfg_ordered;
    logic [WM_W-1:0] cfg_wmode;
    logic [WT_W-1:0] cfg_wofs [NUM_WOFS];
    logic [ID_W-1:0] hist [MAX_WIN];
    int              hist_fill;

    tok_rec  tok_pending [$];
    pair_rec pairs_due [$];

    bit running;
    bit idle_on;
    bit tok_busy;
    int send_gap;
    int stall_left;
    int idle_cycles;
    int err_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return ID_W'($urandom_range(0, 7));
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 16'h8000;
                default: return 16'h7fff;
            endcase
        end
        return ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [WT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return WT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [WT_W-1:0] weight_at(input int d);
        case (cfg_wmode)
            WM_RECIP:  return WT_W'((int'(ONE_Q14) + d / 2) / d);
            WM_CUSTOM: return cfg_wofs[d - 1];
            default:   return ONE_Q14;
        endcase
    endfunction

    // pairs of a new token with its partners, oldest first
    task automatic predict_pairs(input logic [ID_W-1:0] tok, input logic start);
        int      win;
        int      span;
        int      d;
        pair_rec p;
        if (start) hist_fill = 0;
        win = (cfg_window == 0) ? 1 : ((cfg_window > MAX_WIN) ? MAX_WIN : int'(cfg_window));
        span = (hist_fill < win) ? hist_fill : win;
        for (d = span; d >= 1; d--) begin
            if (!cfg_ordered && tok < hist[d - 1]) begin
                p.target    = tok;
                p.collocate = hist[d - 1];
            end else begin
                p.target    = hist[d - 1];
                p.collocate = tok;
            end
            p.weight = weight_at(d);
            p.last   = (d == 1);
            pairs_due.push_back(p);
        end
        for (d = MAX_WIN - 1; d > 0; d--) hist[d] = hist[d - 1];
        hist[0] = tok;
        if (hist_fill < MAX_WIN) hist_fill++;
    endtask

    task automatic report(input string msg);
        if (err_count < 40) $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // driver: token items, launched at the falling edge
    always @(negedge i_clk) begin
        tok_rec cur;
        if (running && !tok_busy) begin
            if (send_gap > 0) begin
                tok_ch.valid <= 1'b0;
                send_gap--;
            end else if (tok_pending.size() > 0 &&
                         !(tok_pending[0].hold && pairs_due.size() > 0)) begin
                cur = tok_pending.pop_front();
                tok_ch.token_id   <= cur.id;
                tok_ch.text_start <= cur.start;
                tok_ch.valid      <= 1'b1;
                tok_busy          <= 1'b1;
                send_gap = idle_on ? pick_gap() : 0;
            end else begin
                tok_ch.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            pair_ch.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            pair_ch.ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            pair_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted tokens, check accepted pairs
    always @(posedge i_clk) begin
        pair_rec want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (tok_ch.valid && tok_ch.ready) begin
                predict_pairs(tok_ch.token_id, tok_ch.text_start);
                tok_busy <= 1'b0;
                moved = 1'b1;
            end
            if (pair_ch.valid && pair_ch.ready) begin
                moved = 1'b1;
                if (pairs_due.size() == 0) begin
                    report($sformatf("unexpected pair %h %h", pair_ch.target_id,
                                     pair_ch.collocate_id));
                end else begin
                    want = pairs_due.pop_front();
                    check_field("target_id", pair_ch.target_id, want.target);
                    check_field("collocate_id", pair_ch.collocate_id, want.collocate);
                    check_field("pair_weight", pair_ch.pair_weight, want.weight);
                    check_field("last_pair", 16'(pair_ch.last_pair), 16'(want.last));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WINDOW_SIZE:  cfg_window  = val[WS_W-1:0];
            CFG_ORDERED_MODE: cfg_ordered = val[0];
            CFG_WEIGHT_MODE:  cfg_wmode   = val[WM_W-1:0];
            default:          cfg_wofs[int'(idx) - int'(CFG_WOFS1)] = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [WS_W-1:0] w, input logic ord,
                                input logic [WM_W-1:0] wm);
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(w));
        write_reg(CFG_ORDERED_MODE, CFG_DATA_W'(ord));
        write_reg(CFG_WEIGHT_MODE, CFG_DATA_W'(wm));
    endtask

    task automatic add_token(input logic [ID_W-1:0] id, input logic start,
                             input bit hold = 1'b0);
        tok_rec t;
        t.id    = id;
        t.start = start;
        t.hold  = hold;
        tok_pending.push_back(t);
    endtask

    // mostly whole texts with random content, some stray text starts
    task automatic add_texts(input int count);
        int added;
        int len;
        int k;
        added = 0;
        while (added < count) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            for (k = 0; k < len; k++) begin
                if (k == 0) add_token(pick_id(), $urandom_range(0, 9) != 0);
                else add_token(pick_id(), $urandom_range(0, 19) == 0);
            end
            added += len;
        end
    endtask

    // block idle: no token in flight and every expected pair received
    task automatic drain();
        while (!(tok_pending.size() == 0 && !tok_busy && pairs_due.size() == 0))
            @(posedge i_clk);
        // a token without partners may still be in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        int k;
        logic [WS_W-1:0] w;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_WINDOW_SIZE;
        i_cfg_data        = '0;
        tok_ch.valid      = 1'b0;
        tok_ch.token_id   = '0;
        tok_ch.text_start = 1'b0;
        pair_ch.ready     = 1'b0;
        running     = 1'b0;
        idle_on     = 1'b1;
        tok_busy    = 1'b0;
        send_gap    = 0;
        stall_left  = 0;
        idle_cycles = 0;
        err_count   = 0;
        cfg_window  = WS_RESET;
        cfg_ordered = 1'b0;
        cfg_wmode   = WM_UNIT;
        for (k = 0; k < NUM_WOFS; k++) cfg_wofs[k] = ONE_Q14;
        for (k = 0; k < MAX_WIN; k++) hist[k] = '0;
        hist_fill = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // reset settings: id extremes, full history, restart, equal ids
        add_token(16'hffff, 1'b1);
        add_token(16'h0000, 1'b0);
        add_token(16'h0001, 1'b0);
        add_token(16'hffff, 1'b0);
        add_token(16'h8000, 1'b0);
        add_token(16'h5a5a, 1'b0);
        add_token(16'ha5a5, 1'b0);
        add_token(16'h0007, 1'b1, 1'b1);
        add_token(16'h0007, 1'b0);
        add_token(16'h0003, 1'b0);
        drain();

        // window above the maximum, earlier token first, reciprocal weights
        apply_config(3'd7, 1'b1, WM_RECIP);
        add_token(16'h0009, 1'b1);
        add_token(16'h0002, 1'b0);
        add_token(16'hffff, 1'b0);
        add_token(16'h0000, 1'b0);
        add_token(16'h0004, 1'b0);
        add_token(16'h0001, 1'b0);
        drain();

        // window zero acts as one, spare weight mode acts as unit
        apply_config(3'd0, 1'b0, WM_SPARE);
        add_token(16'h0040, 1'b0);
        add_token(16'h0003, 1'b0);
        add_token(16'h0003, 1'b0);
        add_token(16'h0000, 1'b1);
        drain();

        // custom weight table with extreme entries
        apply_config(3'd5, 1'b1, WM_CUSTOM);
        write_reg(CFG_WOFS1, 16'h0000);
        write_reg(CFG_WOFS2, 16'hffff);
        write_reg(CFG_WOFS3, 16'h0001);
        write_reg(CFG_WOFS4, 16'h8000);
        write_reg(CFG_WOFS5, 16'h3039);
        add_token(16'h1234, 1'b1);
        add_token(16'h0001, 1'b0);
        add_token(16'hfffe, 1'b0);
        add_token(16'h0000, 1'b0);
        add_token(16'h4321, 1'b0);
        add_token(16'hffff, 1'b0);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            if ($urandom_range(0, 9) < 7) w = WS_W'($urandom_range(1, 5));
            else w = $urandom_range(0, 2) == 0 ? 3'd0 : 3'($urandom_range(6, 7));
            apply_config(w, 1'($urandom_range(0, 1)), WM_W'($urandom_range(0, 3)));
            for (k = 0; k < NUM_WOFS; k++)
                write_reg(t_cfg_idx'(int'(CFG_WOFS1) + k), pick_weight());
            idle_on = (ph != 3);
            add_texts(20);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
